// ===== src/mng_pkg.sv =====
// ----------------------------------------------------------------------------
// mng_pkg: shared types and constants of the MIDI note gate
// Transfer payloads, command codes and MIDI status constants.
// ----------------------------------------------------------------------------
package mng_pkg;

  // Command codes carried in the event transfer.
  localparam logic [1:0] CMD_NOTE_ON       = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF      = 2'd1;
  localparam logic [1:0] CMD_ALL_NOTES_OFF = 2'd2;
  localparam logic [1:0] CMD_GATE_LEVEL    = 2'd3;

  // MIDI status bytes with the channel nibble left at zero.
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_CC       = 8'hB0;

  localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
  localparam logic [3:0] CHANNEL_LAST     = 4'd15;

  // Threshold after reset: one half of full scale.
  localparam logic [15:0] THRESHOLD_RESET = 16'h8000;

  // A table entry holds the channel above the pitch.
  localparam int KEY_W = 11;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  channel;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic        all_channels;
    logic [15:0] gate_level;
  } event_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [3:0] out_channel;
    logic       untracked;
    logic       last;
  } msg_t;

endpackage

// ===== src/mng_ram.sv =====
// ----------------------------------------------------------------------------
// mng_ram: generic single-write, single-read synchronous RAM
// The read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module mng_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/midi_note_gate.sv =====
// ----------------------------------------------------------------------------
// midi_note_gate: MIDI event gate with a table of active notes
// Gates note-ons on a control level, tracks them and flushes them on closing.
// ----------------------------------------------------------------------------
// Events arrive on the event channel (event_valid, event_stall, event_data) and
// MIDI messages leave on the msg channel (msg_valid, msg_stall, msg_data). One
// event is handled at a time; event_stall is high while an event is at work.
// A note-on while the gate is open or a note-off searches the whole table, one
// entry per cycle through the table RAM's read port; its message, if there is
// one, is formed in the finishing step, after which the next event may follow.
// A note-on while the gate is closed and a gate update that does not close the
// gate are handled without leaving idle. A closing gate walks the table: each
// slot is checked, and each active note is read and sent as a note-off.
// An all-notes-off gives one control change per cycle while the output is not
// stalled, sixteen when all channels are chosen. The output register lets the
// next event be taken while a message waits; a stalled message simply holds
// the walk or the finishing step. Reset clears the valid bits of the table,
// closes the gate and sets the threshold to one half; the block takes an event
// straight away. The threshold is written through cfg_write and cfg_data, by
// the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module midi_note_gate #(
  parameter int MAX_ACTIVE_NOTES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           event_valid,
  output logic           event_stall,
  input  mng_pkg::event_t event_data,
  output logic           msg_valid,
  input  logic           msg_stall,
  output mng_pkg::msg_t  msg_data,
  input  logic           cfg_write,
  input  logic [15:0]    cfg_data
);

  localparam int IDX_W = (MAX_ACTIVE_NOTES > 1) ? $clog2(MAX_ACTIVE_NOTES) : 1;
  localparam int CNT_W = $clog2(MAX_ACTIVE_NOTES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_ACTIVE_NOTES);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_FINISH   = 3'd2;
  localparam logic [2:0] ST_FLUSH_RD = 3'd3;
  localparam logic [2:0] ST_FLUSH_EM = 3'd4;
  localparam logic [2:0] ST_CC       = 3'd5;

  logic [2:0]                  state;
  logic [15:0]                 threshold;
  logic                        gate_open;
  logic [MAX_ACTIVE_NOTES-1:0] valid;
  mng_pkg::event_t             item;
  logic [CNT_W-1:0]            idx;
  logic                        chk_v;
  logic [IDX_W-1:0]            chk_idx;
  logic                        match;
  logic [IDX_W-1:0]            match_idx;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic [3:0]                  cc_chan;

  logic                        accept;
  logic                        now_open;
  logic                        out_free;
  logic                        msg_load;
  mng_pkg::msg_t               load_data;
  logic [IDX_W-1:0]            idx_a;
  logic                        ram_we;
  logic                        ram_re;
  logic [mng_pkg::KEY_W-1:0]   ram_rdata;
  logic [mng_pkg::KEY_W-1:0]   item_key;
  logic [MAX_ACTIVE_NOTES-1:0] rest;

  assign event_stall = (state != ST_IDLE);
  assign accept      = event_valid && !event_stall;
  assign now_open    = event_data.gate_level > threshold;
  assign out_free    = !msg_valid || !msg_stall;
  assign idx_a       = idx[IDX_W-1:0];
  assign item_key    = {item.channel, item.note_number};

  // The search reads one entry a cycle; the flush reads only active entries.
  assign ram_re = ((state == ST_SCAN) && (idx != CNT_END)) ||
                  ((state == ST_FLUSH_RD) && (idx != CNT_END) && valid[idx_a]);

  // Active notes that remain once the entry now being flushed is gone.
  always_comb begin
    rest        = valid;
    rest[idx_a] = 1'b0;
  end

  // Message formation and the table write of a newly tracked note.
  always_comb begin
    msg_load  = 1'b0;
    load_data = '0;
    ram_we    = 1'b0;
    unique case (state)
      ST_FINISH: begin
        if (out_free) begin
          if (item.cmd == mng_pkg::CMD_NOTE_ON) begin
            msg_load              = 1'b1;
            load_data.status_byte = mng_pkg::STATUS_NOTE_ON | {4'b0, item.channel};
            load_data.data_one    = item.note_number;
            load_data.data_two    = item.velocity;
            load_data.out_channel = item.channel;
            load_data.untracked   = !match && !free_found;
            load_data.last        = 1'b1;
            ram_we                = !match && free_found;
          end else if (match) begin
            msg_load              = 1'b1;
            load_data.status_byte = mng_pkg::STATUS_NOTE_OFF | {4'b0, item.channel};
            load_data.data_one    = item.note_number;
            load_data.out_channel = item.channel;
            load_data.last        = 1'b1;
          end
        end
      end
      ST_FLUSH_EM: begin
        if (out_free) begin
          msg_load              = 1'b1;
          load_data.status_byte = mng_pkg::STATUS_NOTE_OFF | {4'b0, ram_rdata[10:7]};
          load_data.data_one    = ram_rdata[6:0];
          load_data.out_channel = ram_rdata[10:7];
          load_data.last        = (rest == '0);
        end
      end
      ST_CC: begin
        if (out_free) begin
          msg_load              = 1'b1;
          load_data.status_byte = mng_pkg::STATUS_CC | {4'b0, cc_chan};
          load_data.data_one    = mng_pkg::CC_ALL_NOTES_OFF;
          load_data.out_channel = cc_chan;
          load_data.last        = !item.all_channels || (cc_chan == mng_pkg::CHANNEL_LAST);
        end
      end
      default: begin
      end
    endcase
  end

  mng_ram #(
    .WIDTH (mng_pkg::KEY_W),
    .DEPTH (MAX_ACTIVE_NOTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (item_key),
    .re    (ram_re),
    .raddr (idx_a),
    .rdata (ram_rdata)
  );

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= mng_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  // Sequencer, valid bits and the gate.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gate_open <= 1'b0;
      valid     <= '0;
      chk_v     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item       <= event_data;
            idx        <= '0;
            chk_v      <= 1'b0;
            match      <= 1'b0;
            free_found <= 1'b0;
            cc_chan    <= event_data.all_channels ? 4'd0 : event_data.channel;
            case (event_data.cmd)
              mng_pkg::CMD_NOTE_ON: begin
                if (gate_open) begin
                  state <= ST_SCAN;
                end
              end
              mng_pkg::CMD_NOTE_OFF: begin
                state <= ST_SCAN;
              end
              mng_pkg::CMD_ALL_NOTES_OFF: begin
                valid <= '0;
                state <= ST_CC;
              end
              default: begin
                gate_open <= now_open;
                if (gate_open && !now_open) begin
                  state <= ST_FLUSH_RD;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle and compare the entry read the cycle before.
          if (idx != CNT_END) begin
            idx     <= idx + CNT_W'(1);
            chk_v   <= 1'b1;
            chk_idx <= idx_a;
          end else begin
            chk_v <= 1'b0;
            if (!chk_v) begin
              state <= ST_FINISH;
            end
          end
          if (chk_v) begin
            if (valid[chk_idx] && (ram_rdata == item_key)) begin
              match     <= 1'b1;
              match_idx <= chk_idx;
            end
            if (!valid[chk_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
          end
        end
        ST_FINISH: begin
          if (item.cmd == mng_pkg::CMD_NOTE_ON) begin
            if (out_free) begin
              if (!match && free_found) begin
                valid[free_idx] <= 1'b1;
              end
              state <= ST_IDLE;
            end
          end else if (!match) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            valid[match_idx] <= 1'b0;
            state            <= ST_IDLE;
          end
        end
        ST_FLUSH_RD: begin
          if (idx == CNT_END) begin
            state <= ST_IDLE;
          end else if (valid[idx_a]) begin
            state <= ST_FLUSH_EM;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        ST_FLUSH_EM: begin
          // Each flushed note leaves the table as its message is sent.
          if (out_free) begin
            valid[idx_a] <= 1'b0;
            idx          <= idx + CNT_W'(1);
            state        <= ST_FLUSH_RD;
          end
        end
        ST_CC: begin
          if (out_free) begin
            if (load_data.last) begin
              state <= ST_IDLE;
            end else begin
              cc_chan <= cc_chan + 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: a message waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (msg_load) begin
      msg_valid <= 1'b1;
    end else if (!msg_stall) begin
      msg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_load) begin
      msg_data <= load_data;
    end
  end

  // A new message never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    msg_load |-> (!msg_valid || !msg_stall))
    else $error("message loaded over a stalled message");

  // The final message of a flush leaves the table empty.
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (msg_load && load_data.last && (state == ST_FLUSH_EM)) |=> (valid == '0))
    else $error("table not empty after the last flushed note");

  // A flush that has walked the whole table has cleared every entry.
  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FLUSH_RD) && (idx == CNT_END)) |-> (valid == '0))
    else $error("flush finished with active notes left");

  // Notes are only entered into the table while the gate is open.
  a_write_open: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (gate_open && !valid[free_idx]))
    else $error("table written while gate closed or into a used slot");

endmodule

// ===== tb/sv/note_gate_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// note_gate_tb_pkg: predictor and scoreboard for the MIDI note gate test
// Tracks the gate, the threshold and the active note slots, and checks
// every outgoing message against the oldest predicted one.
// ----------------------------------------------------------------------------
package note_gate_tb_pkg;

  localparam int TABLE_DEPTH  = 32;
  localparam int REPORT_LIMIT = 10;

  class note_gate_scoreboard;

    logic [15:0]   threshold;
    bit            gate_open;
    // Slot layout: valid in bit 11, channel in bits 10..7, pitch in bits 6..0.
    logic [11:0]   slots [TABLE_DEPTH];
    mng_pkg::msg_t expected_msgs [$];
    mng_pkg::msg_t batch [$];
    int unsigned   mismatches;
    int unsigned   msgs_checked;
    int unsigned   untracked_seen;
    int unsigned   flushed_notes;
    int unsigned   closings;

    function new();
      mismatches     = 0;
      msgs_checked   = 0;
      untracked_seen = 0;
      flushed_notes  = 0;
      closings       = 0;
      threshold      = mng_pkg::THRESHOLD_RESET;
      gate_open      = 1'b0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction

    function int tracked_count();
      int n;
      n = 0;
      foreach (slots[i]) if (slots[i][11]) n++;
      return n;
    endfunction

    function int find_slot(logic [11:0] key);
      foreach (slots[i]) if (slots[i] == key) return i;
      return -1;
    endfunction

    // Chooses one of the notes currently held, so that note-offs can hit.
    function bit pick_tracked(output logic [3:0] ch, output logic [6:0] pitch);
      int held [$];
      int k;
      ch    = '0;
      pitch = '0;
      foreach (slots[i]) if (slots[i][11]) held = {held, i};
      if (held.size() == 0) return 1'b0;
      k     = held[$urandom_range(held.size() - 1, 0)];
      ch    = slots[k][10:7];
      pitch = slots[k][6:0];
      return 1'b1;
    endfunction

    function void emit(logic [7:0] status, logic [6:0] d1, logic [6:0] d2,
                       logic [3:0] ch, logic untracked);
      mng_pkg::msg_t m;
      m.status_byte = status | {4'h0, ch};
      m.data_one    = d1;
      m.data_two    = d2;
      m.out_channel = ch;
      m.untracked   = untracked;
      m.last        = 1'b0;
      batch = {batch, m};
    endfunction

    // Applies one accepted event; returns 1 when it produced messages or
    // changed the gate or the slots.
    function bit note_event(mng_pkg::event_t ev);
      logic [11:0]   key;
      int            hit;
      int            free_slot;
      logic          full;
      bit            now_open;
      bit            acted;
      mng_pkg::msg_t m;
      batch.delete();
      acted = 1'b0;
      key   = {1'b1, ev.channel, ev.note_number};
      case (ev.cmd)
        mng_pkg::CMD_NOTE_ON: begin
          if (gate_open) begin
            full = 1'b0;
            if (find_slot(key) < 0) begin
              free_slot = -1;
              foreach (slots[i]) if (free_slot < 0 && !slots[i][11]) free_slot = i;
              if (free_slot >= 0) slots[free_slot] = key;
              else full = 1'b1;
            end
            emit(mng_pkg::STATUS_NOTE_ON, ev.note_number, ev.velocity, ev.channel, full);
            if (full) untracked_seen++;
          end
        end
        mng_pkg::CMD_NOTE_OFF: begin
          hit = find_slot(key);
          if (hit >= 0) begin
            slots[hit] = '0;
            emit(mng_pkg::STATUS_NOTE_OFF, ev.note_number, 7'd0, ev.channel, 1'b0);
          end
        end
        mng_pkg::CMD_ALL_NOTES_OFF: begin
          if (ev.all_channels) begin
            for (int c = 0; c <= mng_pkg::CHANNEL_LAST; c++)
              emit(mng_pkg::STATUS_CC, mng_pkg::CC_ALL_NOTES_OFF, 7'd0, 4'(c), 1'b0);
          end else begin
            emit(mng_pkg::STATUS_CC, mng_pkg::CC_ALL_NOTES_OFF, 7'd0, ev.channel, 1'b0);
          end
          foreach (slots[i]) slots[i] = '0;
          acted = 1'b1;
        end
        default: begin
          now_open = ev.gate_level > threshold;
          if (gate_open && !now_open) begin
            closings++;
            foreach (slots[i]) begin
              if (slots[i][11]) begin
                emit(mng_pkg::STATUS_NOTE_OFF, slots[i][6:0], 7'd0, slots[i][10:7], 1'b0);
                flushed_notes++;
              end
            end
            foreach (slots[i]) slots[i] = '0;
          end
          if (now_open != gate_open) acted = 1'b1;
          gate_open = now_open;
        end
      endcase
      foreach (batch[i]) begin
        m = batch[i];
        m.last = (i == batch.size() - 1);
        expected_msgs = {expected_msgs, m};
      end
      return acted || (batch.size() != 0);
    endfunction

    function string show(mng_pkg::msg_t m);
      return $sformatf("status=%02h data_one=%0d data_two=%0d ch=%0d untracked=%0b last=%0b",
                       m.status_byte, m.data_one, m.data_two, m.out_channel,
                       m.untracked, m.last);
    endfunction

    function void check_msg(mng_pkg::msg_t got);
      mng_pkg::msg_t want;
      msgs_checked++;
      if (expected_msgs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: message with none expected: %s", $realtime, show(got));
        return;
      end
      want = expected_msgs.pop_front();
      if (got.status_byte !== want.status_byte || got.data_one !== want.data_one ||
          got.data_two !== want.data_two || got.out_channel !== want.out_channel ||
          got.untracked !== want.untracked || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch\n  expected %s\n  actual   %s",
                   $realtime, show(want), show(got));
      end
    endfunction

  endclass

endpackage

// ===== tb/sv/midi_note_gate_test.sv =====
// ----------------------------------------------------------------------------
// midi_note_gate_test: self-checking testbench of the MIDI note gate
// Drives directed and random event streams through the block under several
// gate thresholds, with bursty input and a stalling receiver, and compares
// every message with a predictor that tracks the gate and the note slots.
// ----------------------------------------------------------------------------
module midi_note_gate_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Long receiver hold-off, the watchdog's quiet limit, and the pause that
  // covers a search which ends without a message (about two table walks).
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * note_gate_tb_pkg::TABLE_DEPTH + 8;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_mode_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            event_valid;
  logic            event_stall;
  mng_pkg::event_t event_data;
  logic            msg_valid;
  logic            msg_stall;
  mng_pkg::msg_t   msg_data;
  logic            cfg_write;
  logic [15:0]     cfg_data;

  note_gate_tb_pkg::note_gate_scoreboard sb;
  bit          hold_req;
  int          burst_left;
  int unsigned events_sent;
  int unsigned acted_items;
  int unsigned quiet_cycles;
  logic [15:0] last_threshold;

  midi_note_gate #(
    .MAX_ACTIVE_NOTES(note_gate_tb_pkg::TABLE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_data  (event_data),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg_data    (msg_data),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every message transfer is checked against the oldest prediction. Values
  // are sampled at the edge itself, before the block's registers update.
  always @(posedge clk) begin
    if (!rst && msg_valid && !msg_stall) sb.check_msg(msg_data);
  end

  // Watchdog: a long run of cycles with no transfer on either channel means
  // the block has hung, so the run is ended as a failure.
  always @(posedge clk) begin
    if (rst || (event_valid && !event_stall) || (msg_valid && !msg_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d messages outstanding",
               $realtime, QUIET_LIMIT, sb.pending());
      $display("midi_note_gate_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stalls on a pattern of its own, switching between free flow,
  // coin-toss stalls and heavy stalling. When asked, it holds off for a long
  // stretch so that the block backs up and stalls its input.
  initial begin : receiver
    stall_mode_t mode;
    int          seg_left;
    int          hold_left;
    bit          stall;
    msg_stall = 1'b0;
    mode      = STALL_NONE;
    seg_left  = 0;
    hold_left = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_left > 0) begin
        stall = 1'b1;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
      end else if (hold_req) begin
        stall     = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_t'($urandom_range(2, 0));
          seg_left = $urandom_range(60, 10);
        end
        seg_left--;
        case (mode)
          STALL_NONE: stall = 1'b0;
          STALL_COIN: stall = 1'($urandom_range(1, 0));
          default:    stall = ($urandom_range(3, 0) != 0);
        endcase
      end
      msg_stall <= stall;
      @(posedge clk);
    end
  end

  // Event builders. Fields that a command does not use carry random content,
  // so the block is also shown to ignore them.
  function automatic mng_pkg::event_t any_event();
    mng_pkg::event_t ev;
    ev.cmd          = 2'($urandom_range(3, 0));
    ev.channel      = 4'($urandom_range(15, 0));
    ev.note_number  = 7'($urandom_range(127, 0));
    ev.velocity     = 7'($urandom_range(127, 0));
    ev.all_channels = 1'($urandom_range(1, 0));
    ev.gate_level   = 16'($urandom());
    return ev;
  endfunction

  function automatic mng_pkg::event_t note_ev(logic [1:0] cmd, logic [3:0] ch,
                                              logic [6:0] pitch, logic [6:0] vel);
    mng_pkg::event_t ev;
    ev             = any_event();
    ev.cmd         = cmd;
    ev.channel     = ch;
    ev.note_number = pitch;
    ev.velocity    = vel;
    return ev;
  endfunction

  function automatic mng_pkg::event_t level_ev(logic [15:0] lvl);
    mng_pkg::event_t ev;
    ev            = any_event();
    ev.cmd        = mng_pkg::CMD_GATE_LEVEL;
    ev.gate_level = lvl;
    return ev;
  endfunction

  function automatic mng_pkg::event_t all_off_ev(logic [3:0] ch, logic every);
    mng_pkg::event_t ev;
    ev              = any_event();
    ev.cmd          = mng_pkg::CMD_ALL_NOTES_OFF;
    ev.channel      = ch;
    ev.all_channels = every;
    return ev;
  endfunction

  function automatic mng_pkg::event_t random_note_on();
    return note_ev(mng_pkg::CMD_NOTE_ON, 4'($urandom_range(15, 0)),
                   7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
  endfunction

  // A level that opens the gate, where the threshold allows one.
  function automatic logic [15:0] open_level();
    if (sb.threshold == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(32'hFFFF, 32'(sb.threshold) + 1));
  endfunction

  function automatic logic [15:0] shut_level();
    return 16'($urandom_range(32'(sb.threshold), 0));
  endfunction

  // Offers one event and holds it until the transfer; the predictor is told
  // at the accepting edge. Bursts of random length end in random gaps, and
  // valid is only lowered when a gap really follows.
  task automatic send_event(input mng_pkg::event_t ev);
    int gap;
    event_valid <= 1'b1;
    event_data  <= ev;
    @(posedge clk);
    while (event_stall) @(posedge clk);
    events_sent++;
    if (sb.note_event(ev)) acted_items++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(20, 1);
      gap        = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        event_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The sender pauses until every predicted message has arrived, then gives
  // a search that yields no message time to finish.
  task automatic settle();
    event_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called once the block is idle.
  task automatic write_threshold(input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.threshold   = value;
    last_threshold = value;
  endtask

  // A well-formed phrase: open the gate, play and release notes with random
  // content, and usually close the gate again so held notes are flushed.
  task automatic play_phrase();
    int         steps;
    int         r;
    bit         found;
    logic [3:0] ch;
    logic [6:0] pitch;
    send_event(level_ev(open_level()));
    steps = $urandom_range(12, 3);
    repeat (steps) begin
      r     = $urandom_range(99, 0);
      found = sb.pick_tracked(ch, pitch);
      if (r < 40) begin
        send_event(random_note_on());
      end else if (r < 50 && found) begin
        send_event(note_ev(mng_pkg::CMD_NOTE_ON, ch, pitch, 7'($urandom_range(127, 0))));
      end else if (r < 80) begin
        if (found && r < 75)
          send_event(note_ev(mng_pkg::CMD_NOTE_OFF, ch, pitch, 7'($urandom())));
        else send_event(note_ev(mng_pkg::CMD_NOTE_OFF, 4'($urandom()), 7'($urandom()),
                                7'($urandom())));
      end else if (r < 90) begin
        send_event(level_ev(open_level()));
      end else if (r < 95) begin
        send_event(all_off_ev(4'($urandom()), 1'($urandom())));
      end else begin
        send_event(any_event());
      end
    end
    if ($urandom_range(4, 0) != 0) send_event(level_ev(shut_level()));
  endtask

  // Random part: mostly phrases, some noise, and now and then a full pause.
  task automatic run_session(input int target);
    int unsigned start;
    int          tries;
    start = acted_items;
    tries = 0;
    while (acted_items - start < target && tries < 8 * target) begin
      if ($urandom_range(3, 0) == 0) send_event(any_event());
      else play_phrase();
      if ($urandom_range(19, 0) == 0) settle();
      tries++;
    end
  endtask

  // Fills every slot, overflows with note-ons that must come out untracked,
  // then closes the gate for a full flush. The receiver holds off meanwhile,
  // so the block backs up while the sender keeps offering.
  task automatic fill_slots();
    int tries;
    send_event(level_ev(open_level()));
    hold_req = 1'b1;
    tries    = 0;
    while (sb.tracked_count() < note_gate_tb_pkg::TABLE_DEPTH &&
           tries < 4 * note_gate_tb_pkg::TABLE_DEPTH) begin
      send_event(random_note_on());
      tries++;
    end
    repeat (3) send_event(random_note_on());
    send_event(level_ev(shut_level()));
  endtask

  initial begin : stimulus
    sb             = new();
    rst            = 1'b1;
    event_valid    = 1'b0;
    event_data     = '0;
    cfg_write      = 1'b0;
    cfg_data       = '0;
    hold_req       = 1'b0;
    burst_left     = $urandom_range(20, 1);
    events_sent    = 0;
    acted_items    = 0;
    quiet_cycles   = 0;
    last_threshold = mng_pkg::THRESHOLD_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset threshold of one half.
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, 4'd0, 7'd0, 7'd0));    // gate still closed
    send_event(level_ev(mng_pkg::THRESHOLD_RESET));                 // equal does not open
    send_event(level_ev(mng_pkg::THRESHOLD_RESET + 16'd1));         // just above opens
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, 4'd0, 7'd0, 7'd0));
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, mng_pkg::CHANNEL_LAST, 7'd127, 7'd127));
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, mng_pkg::CHANNEL_LAST, 7'd127, 7'd1)); // held
    send_event(note_ev(mng_pkg::CMD_NOTE_OFF, 4'd3, 7'd64, 7'd0));  // not held
    send_event(note_ev(mng_pkg::CMD_NOTE_OFF, 4'd0, 7'd0, 7'd0));
    send_event(level_ev(16'hFFFF));                                 // stays open
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, 4'd7, 7'd60, 7'd100));
    send_event(level_ev(16'h0000));                                 // closes with two held
    send_event(level_ev(mng_pkg::THRESHOLD_RESET));                 // stays closed
    send_event(level_ev(16'hFFFF));
    send_event(level_ev(16'h1234));                                 // closes with none held
    send_event(level_ev(16'hC000));
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, 4'd5, 7'd10, 7'd5));
    send_event(all_off_ev(4'd9, 1'b0));                             // one channel
    send_event(note_ev(mng_pkg::CMD_NOTE_OFF, 4'd5, 7'd10, 7'd0));  // cleared already
    send_event(note_ev(mng_pkg::CMD_NOTE_ON, 4'd1, 7'd2, 7'd3));
    send_event(all_off_ev(4'd4, 1'b1));                             // all sixteen
    send_event(level_ev(16'h0000));
    send_event(all_off_ev(mng_pkg::CHANNEL_LAST, 1'b0));            // gate closed
    settle();

    // Lowest threshold: any non-zero level opens the gate.
    write_threshold(16'h0000);
    run_session(35);
    settle();

    // Highest threshold: the gate can never open.
    write_threshold(16'hFFFF);
    send_event(level_ev(16'hFFFF));
    repeat (16) begin
      case ($urandom_range(3, 0))
        0:       send_event(random_note_on());
        1:       send_event(level_ev(16'($urandom())));
        2:       send_event(all_off_ev(4'($urandom()), 1'($urandom())));
        default: send_event(any_event());
      endcase
    end
    settle();

    // A random threshold strictly inside the range, with the overflow case.
    write_threshold(16'($urandom_range(32'hFFFE, 1)));
    fill_slots();
    run_session(45);
    settle();

    $display("%0d events sent (%0d with effect), %0d messages checked, %0d untracked",
             events_sent, acted_items, sb.msgs_checked, sb.untracked_seen);
    $display("%0d notes flushed over %0d gate closings; thresholds 8000, 0000, ffff, %04h",
             sb.flushed_notes, sb.closings, last_threshold);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("midi_note_gate_test OK");
    end else begin
      $display("%0d mismatches, %0d messages never seen", sb.mismatches, sb.pending());
      $display("midi_note_gate_test NOT OK");
    end
    $finish;
  end

endmodule
